/* sv/vlcc_pkg.sv */
// Package: shared types, codes and reset constants for the light channel controller.
`default_nettype none

package vlcc_pkg;

  localparam int AGE_BITS_DEF = 16;
  localparam int HOLD_BITS    = 16;
  localparam int PHASE_BITS   = 16;
  localparam int NUM_REQ      = 4;
  localparam int IDX_BITS     = 3;

  localparam int REQ_HEAD  = 0;
  localparam int REQ_BRAKE = 1;
  localparam int REQ_LEFT  = 2;
  localparam int REQ_RIGHT = 3;

  localparam logic [HOLD_BITS-1:0] WATCHDOG_RST     = 16'd500;
  localparam logic [HOLD_BITS-1:0] HEAD_HOLD_RST    = 16'd100;
  localparam logic [HOLD_BITS-1:0] BRAKE_HOLD_RST   = 16'd100;
  localparam logic [HOLD_BITS-1:0] TURN_HOLD_RST    = 16'd100;
  localparam logic [HOLD_BITS-1:0] STROBE_HOLD_RST  = 16'd1000;
  localparam logic [HOLD_BITS-1:0] BLINK_PERIOD_RST = 16'd666;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CMD    = 2'd1,
    MODE_STROBE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    FN_NONE       = 3'd0,
    FN_HEAD       = 3'd1,
    FN_LEFT       = 3'd2,
    FN_RIGHT      = 3'd3,
    FN_STOP       = 3'd4,
    FN_FLASH      = 3'd5,
    FN_STOP_LEFT  = 3'd6,
    FN_STOP_RIGHT = 3'd7
  } func_e;

  typedef enum logic [IDX_BITS-1:0] {
    REG_WATCHDOG     = 3'd0,
    REG_HEAD_HOLD    = 3'd1,
    REG_BRAKE_HOLD   = 3'd2,
    REG_TURN_HOLD    = 3'd3,
    REG_STROBE_HOLD  = 3'd4,
    REG_BLINK_PERIOD = 3'd5,
    REG_CH1_FUNC     = 3'd6,
    REG_CH2_FUNC     = 3'd7
  } reg_e;

  typedef struct packed {
    logic [HOLD_BITS-1:0]  watchdog_ms;
    logic [HOLD_BITS-1:0]  headlight_hold_ms;
    logic [HOLD_BITS-1:0]  brake_hold_ms;
    logic [HOLD_BITS-1:0]  turn_hold_ms;
    logic [HOLD_BITS-1:0]  strobe_hold_ms;
    logic [PHASE_BITS-1:0] blink_period_ms;
    func_e                 channel_one_function;
    func_e                 channel_two_function;
  } cfg_t;

  typedef struct packed {
    logic wd;
    logic head;
    logic brake;
    logic left;
    logic right;
    logic strobe;
    logic blink;
  } lights_t;

endpackage

`default_nettype wire

/* sv/vlcc_item_if.sv */
// Interface: input item channel (tick, command or strobe trigger).
`default_nettype none

interface vlcc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       headlight_bit;
  logic       brake_bit;
  logic       left_bit;
  logic       right_bit;

  modport source (output valid, mode, headlight_bit, brake_bit, left_bit, right_bit,
                  input ready);
  modport sink   (input valid, mode, headlight_bit, brake_bit, left_bit, right_bit,
                  output ready);
endinterface

`default_nettype wire

/* sv/vlcc_result_if.sv */
// Interface: result channel carrying the two channel drive states and the fault.
`default_nettype none

interface vlcc_result_if;
  logic valid;
  logic ready;
  logic channel_one_on;
  logic channel_two_on;
  logic fault;

  modport source (output valid, channel_one_on, channel_two_on, fault, input ready);
  modport sink   (input valid, channel_one_on, channel_two_on, fault, output ready);
endinterface

`default_nettype wire

/* sv/vlcc_cfg_if.sv */
// Interface: configuration write channel.
`default_nettype none

interface vlcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/vehicle_light_channel_controller.sv */
// A transferred item updates the state registers; its result is then loaded into the result register and offered.
// Throughput: one item per cycle; input stalls only while a result waits and one more is pending.
// The result register decouples the sides: a new item transfers while a result waits.
// Reset (rst, synchronous): all ages, request bits, seen flags and blink phase clear to zero,
// configuration registers return to their defaults, no result is pending or offered.
`default_nettype none

module vehicle_light_channel_controller #(
  parameter int AGE_BITS = vlcc_pkg::AGE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  vlcc_item_if.sink     item,
  vlcc_result_if.source result,
  vlcc_cfg_if.sink      cfg
);
  import vlcc_pkg::*;

  cfg_t    regs;
  lights_t lights;
  logic    pend;
  logic    advance;

  // configuration writes land directly; the port never back-pressures
  vlcc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // update the state on each item transfer and derive the light flags from it;
  // pend marks an item whose result has not yet reached the result register
  vlcc_state #(
    .AGE_BITS (AGE_BITS)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .regs    (regs),
    .advance (advance),
    .pend    (pend),
    .lights  (lights)
  );

  // map the flags through each channel's function code and hold the result
  vlcc_out u_out (
    .clk     (clk),
    .rst     (rst),
    .result  (result),
    .regs    (regs),
    .lights  (lights),
    .pend    (pend),
    .advance (advance)
  );

  // an accepted item always leaves a pending result behind it
  a_take_pends: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> pend)
    else $error("item transfer did not mark a pending result");

  // input stalls only when both the result register and the state stage are full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (pend && result.valid && !result.ready))
    else $error("input stalled without back-pressure");

  // with nothing pending, a taken result is not repeated
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !pend) |=> !result.valid)
    else $error("result offered with no item behind it");

  // reset leaves nothing pending and nothing offered
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!result.valid && !pend))
    else $error("reset did not clear the pipeline");

endmodule

`default_nettype wire

/* sv/vlcc_regs.sv */
// Configuration register file of the light channel controller.
`default_nettype none

module vlcc_regs (
  input  logic           clk,
  input  logic           rst,
  vlcc_cfg_if.sink       cfg,
  output vlcc_pkg::cfg_t regs
);
  import vlcc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.watchdog_ms          <= WATCHDOG_RST;
      regs.headlight_hold_ms    <= HEAD_HOLD_RST;
      regs.brake_hold_ms        <= BRAKE_HOLD_RST;
      regs.turn_hold_ms         <= TURN_HOLD_RST;
      regs.strobe_hold_ms       <= STROBE_HOLD_RST;
      regs.blink_period_ms      <= BLINK_PERIOD_RST;
      regs.channel_one_function <= FN_NONE;
      regs.channel_two_function <= FN_NONE;
    end else if (cfg.valid) begin
      unique case (reg_e'(cfg.index))
        REG_WATCHDOG:     regs.watchdog_ms          <= cfg.data;
        REG_HEAD_HOLD:    regs.headlight_hold_ms    <= cfg.data;
        REG_BRAKE_HOLD:   regs.brake_hold_ms        <= cfg.data;
        REG_TURN_HOLD:    regs.turn_hold_ms         <= cfg.data;
        REG_STROBE_HOLD:  regs.strobe_hold_ms       <= cfg.data;
        REG_BLINK_PERIOD: regs.blink_period_ms      <= cfg.data;
        REG_CH1_FUNC:     regs.channel_one_function <= func_e'(cfg.data[2:0]);
        REG_CH2_FUNC:     regs.channel_two_function <= func_e'(cfg.data[2:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/vlcc_state.sv */
// State stage: request bits, saturating ages, blink phase and the derived light flags.
`default_nettype none

module vlcc_state #(
  parameter int AGE_BITS = vlcc_pkg::AGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  vlcc_item_if.sink         item,
  input  vlcc_pkg::cfg_t    regs,
  input  logic              advance,
  output logic              pend,
  output vlcc_pkg::lights_t lights
);
  import vlcc_pkg::*;

  localparam int CW = (AGE_BITS > HOLD_BITS) ? AGE_BITS : HOLD_BITS;

  logic [NUM_REQ-1:0]    request_bits, request_bits_next;
  logic [AGE_BITS-1:0]   command_age, command_age_next;
  logic [AGE_BITS-1:0]   request_age [NUM_REQ];
  logic [AGE_BITS-1:0]   request_age_next [NUM_REQ];
  logic [NUM_REQ-1:0]    request_seen, request_seen_next;
  logic [AGE_BITS-1:0]   strobe_age, strobe_age_next;
  logic                  strobe_seen, strobe_seen_next;
  logic [PHASE_BITS-1:0] blink_phase, blink_phase_next;
  logic [PHASE_BITS:0]   phase_inc;
  logic [HOLD_BITS-1:0]  hold [NUM_REQ];
  logic [NUM_REQ-1:0]    req_on;
  logic                  take;

  function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  assign item.ready = !pend || advance;
  assign take       = item.valid && item.ready;
  assign phase_inc  = {1'b0, blink_phase} + 1'b1;

  always_comb begin
    request_bits_next = request_bits;
    command_age_next  = command_age;
    request_seen_next = request_seen;
    strobe_age_next   = strobe_age;
    strobe_seen_next  = strobe_seen;
    blink_phase_next  = blink_phase;
    for (int i = 0; i < NUM_REQ; i++) begin
      request_age_next[i] = request_age[i];
    end
    if (take) begin
      case (mode_e'(item.mode))
        MODE_TICK: begin
          command_age_next = age_inc(command_age);
          strobe_age_next  = age_inc(strobe_age);
          for (int i = 0; i < NUM_REQ; i++) begin
            request_age_next[i] = age_inc(request_age[i]);
          end
          // wrap the phase where the period ends; a period below two pins it at zero
          if (phase_inc >= {1'b0, regs.blink_period_ms}) begin
            blink_phase_next = '0;
          end else begin
            blink_phase_next = phase_inc[PHASE_BITS-1:0];
          end
        end
        MODE_CMD: begin
          request_bits_next[REQ_HEAD]  = item.headlight_bit;
          request_bits_next[REQ_BRAKE] = item.brake_bit;
          request_bits_next[REQ_LEFT]  = item.left_bit;
          request_bits_next[REQ_RIGHT] = item.right_bit;
          command_age_next = '0;
          for (int i = 0; i < NUM_REQ; i++) begin
            if (request_bits_next[i]) begin
              request_age_next[i]  = '0;
              request_seen_next[i] = 1'b1;
            end
          end
        end
        MODE_STROBE: begin
          strobe_age_next  = '0;
          strobe_seen_next = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      request_bits <= '0;
      command_age  <= '0;
      request_seen <= '0;
      strobe_age   <= '0;
      strobe_seen  <= 1'b0;
      blink_phase  <= '0;
      for (int i = 0; i < NUM_REQ; i++) begin
        request_age[i] <= '0;
      end
    end else begin
      if (take) begin
        pend <= 1'b1;
      end else if (advance) begin
        pend <= 1'b0;
      end
      request_bits <= request_bits_next;
      command_age  <= command_age_next;
      request_seen <= request_seen_next;
      strobe_age   <= strobe_age_next;
      strobe_seen  <= strobe_seen_next;
      blink_phase  <= blink_phase_next;
      for (int i = 0; i < NUM_REQ; i++) begin
        request_age[i] <= request_age_next[i];
      end
    end
  end

  assign hold[REQ_HEAD]  = regs.headlight_hold_ms;
  assign hold[REQ_BRAKE] = regs.brake_hold_ms;
  assign hold[REQ_LEFT]  = regs.turn_hold_ms;
  assign hold[REQ_RIGHT] = regs.turn_hold_ms;

  always_comb begin
    for (int i = 0; i < NUM_REQ; i++) begin
      req_on[i] = request_bits[i] ||
                  (request_seen[i] && (CW'(request_age[i]) <= CW'(hold[i])));
    end
  end

  assign lights.wd     = CW'(command_age) > CW'(regs.watchdog_ms);
  assign lights.head   = !lights.wd && req_on[REQ_HEAD];
  assign lights.brake  = !lights.wd && req_on[REQ_BRAKE];
  assign lights.left   = !lights.wd && req_on[REQ_LEFT];
  assign lights.right  = !lights.wd && req_on[REQ_RIGHT];
  assign lights.strobe = strobe_seen && (CW'(strobe_age) <= CW'(regs.strobe_hold_ms));
  assign lights.blink  = blink_phase < (regs.blink_period_ms >> 1);

endmodule

`default_nettype wire

/* sv/vlcc_out.sv */
// Output stage: per-channel function select into the result register.
`default_nettype none

module vlcc_out (
  input  logic              clk,
  input  logic              rst,
  vlcc_result_if.source     result,
  input  vlcc_pkg::cfg_t    regs,
  input  vlcc_pkg::lights_t lights,
  input  logic              pend,
  output logic              advance
);
  import vlcc_pkg::*;

  logic load;
  logic ch1, ch2;

  function automatic logic pick(input func_e fn, input lights_t l);
    logic on;
    unique case (fn)
      FN_NONE:       on = 1'b0;
      FN_HEAD:       on = l.head;
      FN_LEFT:       on = l.left && l.blink;
      FN_RIGHT:      on = l.right && l.blink;
      FN_STOP:       on = l.brake;
      FN_FLASH:      on = l.strobe;
      FN_STOP_LEFT:  on = l.left ? l.blink : l.brake;
      FN_STOP_RIGHT: on = l.right ? l.blink : l.brake;
      default:       on = 1'b0;
    endcase
    return on;
  endfunction

  assign advance = !result.valid || result.ready;
  assign load    = pend && advance;
  assign ch1     = pick(regs.channel_one_function, lights);
  assign ch2     = pick(regs.channel_two_function, lights);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.channel_one_on <= ch1;
      result.channel_two_on <= ch2;
      result.fault          <= lights.wd;
    end
  end

endmodule

`default_nettype wire
